/* hdl/sdq_pkg.sv */
// sdq_pkg: operation and status codes, cell control type and decode helpers
// for the sorted deque table. No dependencies.
package sdq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_FRONT    = 3'd0,
    FN_PUSH_BACK     = 3'd1,
    FN_POP_FRONT     = 3'd2,
    FN_POP_BACK      = 3'd3,
    FN_REMOVE        = 3'd4,
    FN_INSERT_SORTED = 3'd5
  } func_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  // write strobes handed to every cell in the apply cycle
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  function automatic logic is_insert(logic [FuncW-1:0] f);
    return f inside {FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_SORTED};
  endfunction

  function automatic logic is_pop(logic [FuncW-1:0] f);
    return f inside {FN_POP_FRONT, FN_POP_BACK};
  endfunction

endpackage

/* hdl/sdq_if.sv */
// sdq_in_if / sdq_out_if: valid-ready channels for operations and results.
// Plain logic payload, no dependencies.
interface sdq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sdq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_out;
  logic [1:0]         status;
  logic [4:0]         count;

  modport source (output valid, output value_out, output status, output count, input ready);
  modport sink   (input valid, input value_out, input status, input count, output ready);
endinterface

/* hdl/sorted_deque_table_unit.sv */
// sorted_deque_table_unit: top level; row of sdq_cell slots, prefix scan of the
// match flags, pop value reduction and result register. Uses sdq_pkg, sdq_if.
//
//  channel | dir | payload                    | transfer
//  in_i    | in  | func[2:0], value[31:0]     | valid & ready
//  out_o   | out | value_out, status, count   | valid & ready
//
// an operation runs from its transfer through S_SCAN, one scan step per prefix-OR
// level, then through S_APPLY to a valid result
// one operation is in flight at a time, so in_i takes no new transfer until the
// previous operation has left S_APPLY
// in_i.ready is low while an operation runs; apply waits while a result waits on out_o
// reset clears the count and the control; entries hold no reset value
module sorted_deque_table_unit import sdq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdq_in_if.sink    in_i,
  sdq_out_if.source out_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned L     = $clog2(CAPACITY);
  localparam int unsigned LVL_W = (L > 1) ? $clog2(L) : 1;
  localparam int unsigned NP    = 1 << L;
  localparam int unsigned EW    = (CW > CountW) ? CW : CountW;

  state_e state_q, state_d;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [FuncW-1:0] op_q;
  logic [DataW-1:0] val_q;
  logic [CAPACITY-1:0] p_q, p_d;
  logic [DataW-1:0] red_q [NP];
  logic [DataW-1:0] red_d [NP];

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_val_q, out_val_d;
  status_e          out_stat_q, out_stat_d;
  logic [CW-1:0]    out_cnt_q, out_cnt_d;
  logic [EW-1:0]    out_cnt_ext;

  logic [CAPACITY-1:0] match, cell_valid, cell_nvalid, left_at;
  logic [DataW-1:0]    entry  [CAPACITY];
  logic [DataW-1:0]    left_e [CAPACITY];
  logic [DataW-1:0]    right_e[CAPACITY];
  cell_ctl_t           cell_ctl;

  logic in_xfer, out_xfer, full, empty, found;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  assign full       = (cnt_q == CW'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign found      = p_q[CAPACITY-1];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_valid[i]  = cnt_q > CW'(i);
      cell_nvalid[i] = cnt_q > CW'(i + 1);
      left_at[i]     = (i == 0) ? 1'b0 : p_q[(i == 0) ? 0 : i - 1];
      left_e[i]      = (i == 0) ? '0 : entry[(i == 0) ? 0 : i - 1];
      right_e[i]     = (i == CAPACITY - 1) ? entry[i] : entry[(i == CAPACITY - 1) ? i : i + 1];
    end
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    sdq_cell u_cell (
      .clk_i         (clk_i),
      .func_i        (in_i.func),
      .value_i       (in_i.value),
      .new_value_i   (val_q),
      .valid_i       (cell_valid[gi]),
      .next_valid_i  (cell_nvalid[gi]),
      .first_i       (1'(gi == 0)),
      .ctl_i         (cell_ctl),
      .at_i          (p_q[gi]),
      .left_at_i     (left_at[gi]),
      .left_entry_i  (left_e[gi]),
      .right_entry_i (right_e[gi]),
      .match_o       (match[gi]),
      .entry_o       (entry[gi])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lvl_d       = lvl_q;
    p_d         = p_q;
    red_d       = red_q;
    cell_ctl    = '0;
    out_valid_d = out_valid_q && !out_xfer;
    out_val_d   = out_val_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          p_d   = match;
          lvl_d = '0;
          for (int i = 0; i < NP; i++) begin
            red_d[i] = '0;
          end
          for (int i = 0; i < CAPACITY; i++) begin
            red_d[i] = match[i] ? entry[i] : '0;
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // one prefix-OR level and one reduction level per cycle
        p_d = p_q | (p_q << (CAPACITY'(1) << lvl_q));
        for (int j = 0; j < NP / 2; j++) begin
          red_d[j] = red_q[2*j] | red_q[2*j+1];
        end
        lvl_d = lvl_q + LVL_W'(1);
        if (lvl_q == LVL_W'(L - 1)) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        // hold while the previous result still waits on out_o
        if (!out_valid_q || out_xfer) begin
          out_val_d  = '0;
          out_stat_d = STAT_OK;
          if (is_insert(op_q)) begin
            if (full) begin
              out_stat_d = STAT_FULL;
            end else begin
              cell_ctl.ins = 1'b1;
              cnt_d        = cnt_q + CW'(1);
            end
          end else if (is_pop(op_q)) begin
            if (empty) begin
              out_stat_d = STAT_EMPTY;
            end else begin
              cell_ctl.rem = 1'b1;
              cnt_d        = cnt_q - CW'(1);
              out_val_d    = red_q[0];
            end
          end else if (op_q == FN_REMOVE) begin
            if (found) begin
              cell_ctl.rem = 1'b1;
              cnt_d        = cnt_q - CW'(1);
            end else begin
              out_stat_d = STAT_NOTFOUND;
            end
          end
          out_cnt_d   = cnt_d;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= in_i.func;
      val_q <= in_i.value;
    end
    p_q        <= p_d;
    red_q      <= red_d;
    out_val_q  <= out_val_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_cnt_ext     = EW'(out_cnt_q);
  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_val_q;
  assign out_o.status    = out_stat_q;
  assign out_o.count     = out_cnt_ext[CountW-1:0];

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.func == FN_POP_FRONT || in_i.func == FN_POP_BACK) |-> $onehot0(match))
    else $error("pop selects more than one cell");

  a_apply_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |=> out_valid_q)
    else $error("apply cycle left no result");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_APPLY |=> $stable(cnt_q))
    else $error("count changed outside apply");
`endif

endmodule

/* hdl/sdq_cell.sv */
// sdq_cell: one slot of the table; holds an entry, flags a match for the
// incoming operation and shifts toward either neighbor. Uses sdq_pkg.
module sdq_cell import sdq_pkg::*; (
  input  logic             clk_i,
  input  logic [FuncW-1:0] func_i,
  input  logic [DataW-1:0] value_i,
  input  logic [DataW-1:0] new_value_i,
  input  logic             valid_i,
  input  logic             next_valid_i,
  input  logic             first_i,
  input  cell_ctl_t        ctl_i,
  input  logic             at_i,
  input  logic             left_at_i,
  input  logic [DataW-1:0] left_entry_i,
  input  logic [DataW-1:0] right_entry_i,
  output logic             match_o,
  output logic [DataW-1:0] entry_o
);

  logic [DataW-1:0] entry_q, entry_d;

  always_comb begin
    case (func_i)
      FN_PUSH_FRONT:    match_o = 1'b1;
      FN_PUSH_BACK:     match_o = ~valid_i;
      FN_INSERT_SORTED: match_o = ~valid_i | ($signed(entry_q) >= $signed(value_i));
      FN_POP_FRONT:     match_o = valid_i & first_i;
      FN_POP_BACK:      match_o = valid_i & ~next_valid_i;
      FN_REMOVE:        match_o = valid_i & (entry_q == value_i);
      default:          match_o = 1'b0;
    endcase
  end

  // at_i: this cell sits at or behind the chosen position
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && at_i) begin
      entry_d = left_at_i ? left_entry_i : new_value_i;
    end else if (ctl_i.rem && at_i) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
